// ----- hw/rtl/aff_pkg.sv -----
// ----------------------------------------------------------------------------
// aff_pkg
// Shared widths, codes, item record and saturation helper for the 2D
// scale, rotate and translate point transform.
// ----------------------------------------------------------------------------
package aff_pkg;

   // Vector values are signed fixed point with FRAC_BITS fraction bits.
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // Rotor parts are signed Q2.30.
   localparam int ROT_W    = 32;
   localparam int ROT_FRAC = 30;

   // Derived widths.
   localparam int QUO_W  = DATA_WIDTH + FRAC_BITS;
   localparam int PROD_W = (DATA_WIDTH > ROT_W) ? DATA_WIDTH : ROT_W;
   localparam int WIDE_W = DATA_WIDTH + PROD_W + 2;
   localparam int CSR_W  = PROD_W;
   localparam int IDX_W  = 3;

   // Unit latencies in cycles.
   localparam int MUL_LAT  = 2;
   localparam int ROT_LAT  = 3;
   localparam int DIV_LAT  = QUO_W + 2;
   localparam int SQRT_LAT = DATA_WIDTH + 2;

   typedef enum logic [1:0] {
      MODE_FWD,
      MODE_INV,
      MODE_NRM,
      MODE_INVN
   } mode_type;

   typedef enum logic [IDX_W-1:0] {
      REG_POS_X,
      REG_POS_Y,
      REG_SCALE_X,
      REG_SCALE_Y,
      REG_ROT_RE,
      REG_ROT_IM
   } reg_idx_type;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [ROT_W-1:0]      rot_type;
   typedef logic signed [WIDE_W-1:0]     wide_type;

   // One request as it moves down the pipeline.
   typedef struct packed {
      mode_type mode;
      logic     fault;
      data_type x;
      data_type y;
   } item_type;

   localparam wide_type SAT_HI = {{(WIDE_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam wide_type SAT_LO = {{(WIDE_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
   localparam data_type DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   localparam wide_type RND_FRAC = wide_type'(1) << (FRAC_BITS - 1);
   localparam wide_type RND_ROT  = wide_type'(1) << (ROT_FRAC - 1);

   localparam data_type SCALE_ONE   = data_type'(1) << FRAC_BITS;
   localparam rot_type  ROT_ONE     = rot_type'(1) << ROT_FRAC;
   localparam rot_type  ROT_NEG_ONE = -ROT_ONE;

   // Clamp a wide signed value to the data range.
   function automatic data_type sat_f(input wide_type v);
      data_type res;
      if (v > SAT_HI) begin
         res = DATA_MAX;
      end else if (v < SAT_LO) begin
         res = DATA_MIN;
      end else begin
         res = v[DATA_WIDTH-1:0];
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/aff_mul.sv -----
// ----------------------------------------------------------------------------
// aff_mul
// Two-lane scale multiplier: product, then round half up and saturate.
// ----------------------------------------------------------------------------
module aff_mul (
   input  logic              clock,
   input  aff_pkg::data_type a_x,
   input  aff_pkg::data_type a_y,
   input  aff_pkg::data_type s_x,
   input  aff_pkg::data_type s_y,
   output aff_pkg::data_type z_x,
   output aff_pkg::data_type z_y
);
   import aff_pkg::*;

   logic signed [2*DATA_WIDTH-1:0] prod_x_ff;
   logic signed [2*DATA_WIDTH-1:0] prod_y_ff;
   data_type                       z_x_ff;
   data_type                       z_y_ff;

   // First stage holds the full products.
   always_ff @(posedge clock) begin
      prod_x_ff <= a_x * s_x;
      prod_y_ff <= a_y * s_y;
   end

   // Second stage rounds off the fraction bits and saturates.
   always_ff @(posedge clock) begin
      z_x_ff <= sat_f((wide_type'(prod_x_ff) + RND_FRAC) >>> FRAC_BITS);
      z_y_ff <= sat_f((wide_type'(prod_y_ff) + RND_FRAC) >>> FRAC_BITS);
   end

   assign z_x = z_x_ff;
   assign z_y = z_y_ff;

endmodule

// ----- hw/rtl/aff_rot.sv -----
// ----------------------------------------------------------------------------
// aff_rot
// Rotor multiply: four products, then the sums, then round and saturate.
// ----------------------------------------------------------------------------
module aff_rot (
   input  logic              clock,
   input  aff_pkg::data_type a,
   input  aff_pkg::data_type b,
   input  aff_pkg::rot_type  re,
   input  aff_pkg::rot_type  im,
   input  logic              conj,
   output aff_pkg::data_type z_x,
   output aff_pkg::data_type z_y
);
   import aff_pkg::*;

   localparam int P_W = DATA_WIDTH + ROT_W;
   localparam int S_W = P_W + 1;

   logic signed [P_W-1:0] p_ar_ff;
   logic signed [P_W-1:0] p_bi_ff;
   logic signed [P_W-1:0] p_ai_ff;
   logic signed [P_W-1:0] p_br_ff;
   logic                  conj_ff;
   logic signed [S_W-1:0] sum_x_ff;
   logic signed [S_W-1:0] sum_y_ff;
   data_type              z_x_ff;
   data_type              z_y_ff;

   // Products of each component with each rotor part.
   always_ff @(posedge clock) begin
      p_ar_ff <= a * re;
      p_bi_ff <= b * im;
      p_ai_ff <= a * im;
      p_br_ff <= b * re;
      conj_ff <= conj;
   end

   // The conjugate rotor flips the sign of the sine terms.
   always_ff @(posedge clock) begin
      if (conj_ff) begin
         sum_x_ff <= S_W'(p_ar_ff) + S_W'(p_bi_ff);
         sum_y_ff <= S_W'(p_br_ff) - S_W'(p_ai_ff);
      end else begin
         sum_x_ff <= S_W'(p_ar_ff) - S_W'(p_bi_ff);
         sum_y_ff <= S_W'(p_br_ff) + S_W'(p_ai_ff);
      end
   end

   // Round half up at the rotor fraction and saturate.
   always_ff @(posedge clock) begin
      z_x_ff <= sat_f((wide_type'(sum_x_ff) + RND_ROT) >>> ROT_FRAC);
      z_y_ff <= sat_f((wide_type'(sum_y_ff) + RND_ROT) >>> ROT_FRAC);
   end

   assign z_x = z_x_ff;
   assign z_y = z_y_ff;

endmodule

// ----- hw/rtl/aff_isqrt.sv -----
// ----------------------------------------------------------------------------
// aff_isqrt
// Vector length: squares, sum, then one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module aff_isqrt (
   input  logic                            clock,
   input  aff_pkg::data_type               a,
   input  aff_pkg::data_type               b,
   output logic [aff_pkg::DATA_WIDTH-1:0]  len
);
   import aff_pkg::*;

   localparam int RAD_W = 2 * DATA_WIDTH;
   localparam int REM_W = DATA_WIDTH + 2;
   localparam int STEPS = DATA_WIDTH;

   logic signed [RAD_W-1:0] sq_a_ff;
   logic signed [RAD_W-1:0] sq_b_ff;
   logic [RAD_W-1:0]        rad_ff  [STEPS+1];
   logic [RAD_W-1:0]        rad_in  [STEPS+1];
   logic [REM_W-1:0]        rem_ff  [STEPS+1];
   logic [REM_W-1:0]        rem_in  [STEPS+1];
   logic [DATA_WIDTH-1:0]   root_ff [STEPS+1];
   logic [DATA_WIDTH-1:0]   root_in [STEPS+1];

   // Squares of the two components.
   always_ff @(posedge clock) begin
      sq_a_ff <= a * a;
      sq_b_ff <= b * b;
   end

   // Sum of squares, then the digit-by-digit root, two radicand bits a stage.
   always_comb begin
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] test;
      rad_in[0]  = $unsigned(sq_a_ff) + $unsigned(sq_b_ff);
      rem_in[0]  = '0;
      root_in[0] = '0;
      for (int i = 0; i < STEPS; i++) begin
         trial = {rem_ff[i][DATA_WIDTH-1:0], rad_ff[i][RAD_W-1 -: 2]};
         test  = {root_ff[i], 2'b01};
         if (trial >= test) begin
            rem_in[i+1]  = trial - test;
            root_in[i+1] = {root_ff[i][DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in[i+1]  = trial;
            root_in[i+1] = {root_ff[i][DATA_WIDTH-2:0], 1'b0};
         end
         rad_in[i+1] = {rad_ff[i][RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= STEPS; i++) begin
         rad_ff[i]  <= rad_in[i];
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
      end
   end

   assign len = root_ff[STEPS];

endmodule

// ----- hw/rtl/aff_div.sv -----
// ----------------------------------------------------------------------------
// aff_div
// Signed fixed-point divide, truncated toward zero and saturated.
// One quotient bit per pipeline stage on the magnitudes.
// ----------------------------------------------------------------------------
module aff_div (
   input  logic                            clock,
   input  aff_pkg::data_type               a,
   input  logic [aff_pkg::DATA_WIDTH-1:0]  den,
   input  logic                            den_neg,
   output aff_pkg::data_type               q
);
   import aff_pkg::*;

   logic [DATA_WIDTH-1:0] a_mag;
   logic [QUO_W-1:0]      num_ff [QUO_W+1];
   logic [QUO_W-1:0]      num_in [QUO_W+1];
   logic [DATA_WIDTH-1:0] rem_ff [QUO_W+1];
   logic [DATA_WIDTH-1:0] rem_in [QUO_W+1];
   logic [DATA_WIDTH-1:0] den_ff [QUO_W+1];
   logic [DATA_WIDTH-1:0] den_in [QUO_W+1];
   logic                  neg_ff [QUO_W+1];
   logic                  neg_in [QUO_W+1];
   wide_type              mag_w;
   data_type              q_ff;

   // Entry takes magnitudes and scales the dividend by one.
   assign a_mag = a[DATA_WIDTH-1] ? $unsigned(-a) : $unsigned(a);

   // Restoring division: shift in a dividend bit, subtract where it fits.
   always_comb begin
      logic [DATA_WIDTH:0] trial;
      logic [DATA_WIDTH:0] diff;
      logic                fits;
      num_in[0] = {a_mag, {FRAC_BITS{1'b0}}};
      rem_in[0] = '0;
      den_in[0] = den;
      neg_in[0] = a[DATA_WIDTH-1] ^ den_neg;
      for (int i = 0; i < QUO_W; i++) begin
         trial = {rem_ff[i], num_ff[i][QUO_W-1]};
         diff  = trial - {1'b0, den_ff[i]};
         fits  = (trial >= {1'b0, den_ff[i]});
         rem_in[i+1] = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
         num_in[i+1] = {num_ff[i][QUO_W-2:0], fits};
         den_in[i+1] = den_ff[i];
         neg_in[i+1] = neg_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= QUO_W; i++) begin
         num_ff[i] <= num_in[i];
         rem_ff[i] <= rem_in[i];
         den_ff[i] <= den_in[i];
         neg_ff[i] <= neg_in[i];
      end
   end

   // Apply the sign and saturate the quotient.
   assign mag_w = {{(WIDE_W-QUO_W){1'b0}}, num_ff[QUO_W]};

   always_ff @(posedge clock) begin
      q_ff <= sat_f(neg_ff[QUO_W] ? -mag_w : mag_w);
   end

   assign q = q_ff;

endmodule

// ----- hw/rtl/affine_2d_point_transform_top.sv -----
// ----------------------------------------------------------------------------
// affine_2d_point_transform_top
// Path: the request register and position subtract, then the scale, rotation
// and post sections, the square root and the normalize dividers, then the result
// register; each divider gives one quotient bit a stage, the root one root bit a stage.
// Throughput: one request per cycle; busy is high only in reset and results
// are not held.
// Reset: synchronous, active high; clears the valid chain and loads defaults.
// ----------------------------------------------------------------------------
module affine_2d_point_transform_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_mode,
   input  aff_pkg::data_type          req_in_x,
   input  aff_pkg::data_type          req_in_y,
   output logic                       rsp_strobe,
   output aff_pkg::data_type          rsp_out_x,
   output aff_pkg::data_type          rsp_out_y,
   output logic                       rsp_fault,
   input  logic                       csr_we,
   input  logic [aff_pkg::IDX_W-1:0]  csr_index,
   input  logic [aff_pkg::CSR_W-1:0]  csr_wdata
);
   import aff_pkg::*;

   localparam int LAST    = 1 + 3 * DIV_LAT + ROT_LAT + SQRT_LAT;
   localparam int MDLY    = DIV_LAT - MUL_LAT;
   localparam int RSP_DLY = LAST + 2;

   // Configuration registers.
   data_type pos_x_ff;
   data_type pos_y_ff;
   data_type scl_x_ff;
   data_type scl_y_ff;
   rot_type  rot_re_ff;
   rot_type  rot_im_ff;

   rot_type               re_c;
   rot_type               im_c;
   logic                  scale_zero;
   logic [DATA_WIDTH-1:0] scl_x_mag;
   logic [DATA_WIDTH-1:0] scl_y_mag;

   logic          accept;
   logic [LAST:0] vld_ff;

   item_type s0_ff;
   item_type s1_ff;
   item_type s1_in;
   item_type s2;
   item_type s3;
   item_type s4;
   item_type s5;
   item_type post_in;
   item_type sq_in;

   item_type scl_d_ff  [DIV_LAT];
   data_type scl_mx_ff [MDLY];
   data_type scl_my_ff [MDLY];
   data_type scl_qx;
   data_type scl_qy;
   data_type scl_mx;
   data_type scl_my;

   item_type rot_d_ff [ROT_LAT];
   logic     rot_conj;
   data_type rot_x;
   data_type rot_y;

   item_type post_d_ff  [DIV_LAT];
   data_type post_mx_ff [MDLY];
   data_type post_my_ff [MDLY];
   data_type post_qx;
   data_type post_qy;
   data_type post_mx;
   data_type post_my;

   item_type              sq_d_ff [SQRT_LAT];
   item_type              nd_d_ff [DIV_LAT];
   logic [DATA_WIDTH-1:0] nrm_len;
   data_type              nrm_qx;
   data_type              nrm_qy;

   logic     rsp_strobe_ff;
   data_type rsp_x_ff;
   data_type rsp_y_ff;
   logic     rsp_fault_ff;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         scl_x_ff  <= SCALE_ONE;
         scl_y_ff  <= SCALE_ONE;
         rot_re_ff <= ROT_ONE;
         rot_im_ff <= '0;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_index))
            REG_POS_X:   pos_x_ff  <= csr_wdata[DATA_WIDTH-1:0];
            REG_POS_Y:   pos_y_ff  <= csr_wdata[DATA_WIDTH-1:0];
            REG_SCALE_X: scl_x_ff  <= csr_wdata[DATA_WIDTH-1:0];
            REG_SCALE_Y: scl_y_ff  <= csr_wdata[DATA_WIDTH-1:0];
            REG_ROT_RE:  rot_re_ff <= csr_wdata[ROT_W-1:0];
            REG_ROT_IM:  rot_im_ff <= csr_wdata[ROT_W-1:0];
            default: ;
         endcase
      end
   end

   // Rotor clamped to unit range; scale magnitudes for the dividers.
   always_comb begin
      if (rot_re_ff > ROT_ONE) begin
         re_c = ROT_ONE;
      end else if (rot_re_ff < ROT_NEG_ONE) begin
         re_c = ROT_NEG_ONE;
      end else begin
         re_c = rot_re_ff;
      end
      if (rot_im_ff > ROT_ONE) begin
         im_c = ROT_ONE;
      end else if (rot_im_ff < ROT_NEG_ONE) begin
         im_c = ROT_NEG_ONE;
      end else begin
         im_c = rot_im_ff;
      end
   end

   assign scale_zero = (scl_x_ff == '0) || (scl_y_ff == '0);
   assign scl_x_mag  = scl_x_ff[DATA_WIDTH-1] ? $unsigned(-scl_x_ff) : $unsigned(scl_x_ff);
   assign scl_y_mag  = scl_y_ff[DATA_WIDTH-1] ? $unsigned(-scl_y_ff) : $unsigned(scl_y_ff);

   // The pipeline never stalls; requests are refused only during reset.
   assign busy   = reset;
   assign accept = start && !busy;

   // Valid bits run alongside the request data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         vld_ff        <= {vld_ff[LAST-1:0], accept};
         rsp_strobe_ff <= vld_ff[LAST];
      end
   end

   // Request capture and position subtract for the inverse transform.
   always_comb begin
      s1_in = s0_ff;
      if (s0_ff.mode == MODE_INV) begin
         s1_in.x = sat_f(wide_type'(s0_ff.x) - wide_type'(pos_x_ff));
         s1_in.y = sat_f(wide_type'(s0_ff.y) - wide_type'(pos_y_ff));
      end
   end

   always_ff @(posedge clock) begin
      s0_ff.mode  <= mode_type'(req_mode);
      s0_ff.fault <= 1'b0;
      s0_ff.x     <= req_in_x;
      s0_ff.y     <= req_in_y;
      s1_ff       <= s1_in;
   end

   // Scale section: multiply for forward, divide for normal.
   aff_div u_scl_div_x (
      .clock   (clock),
      .a       (s1_ff.x),
      .den     (scl_x_mag),
      .den_neg (scl_x_ff[DATA_WIDTH-1]),
      .q       (scl_qx)
   );

   aff_div u_scl_div_y (
      .clock   (clock),
      .a       (s1_ff.y),
      .den     (scl_y_mag),
      .den_neg (scl_y_ff[DATA_WIDTH-1]),
      .q       (scl_qy)
   );

   aff_mul u_scl_mul (
      .clock (clock),
      .a_x   (s1_ff.x),
      .a_y   (s1_ff.y),
      .s_x   (scl_x_ff),
      .s_y   (scl_y_ff),
      .z_x   (scl_mx),
      .z_y   (scl_my)
   );

   always_ff @(posedge clock) begin
      scl_d_ff[0]  <= s1_ff;
      scl_mx_ff[0] <= scl_mx;
      scl_my_ff[0] <= scl_my;
      for (int i = 1; i < DIV_LAT; i++) begin
         scl_d_ff[i] <= scl_d_ff[i-1];
      end
      for (int i = 1; i < MDLY; i++) begin
         scl_mx_ff[i] <= scl_mx_ff[i-1];
         scl_my_ff[i] <= scl_my_ff[i-1];
      end
   end

   always_comb begin
      s2 = scl_d_ff[DIV_LAT-1];
      unique case (s2.mode)
         MODE_FWD: begin
            s2.x = scl_mx_ff[MDLY-1];
            s2.y = scl_my_ff[MDLY-1];
         end
         MODE_NRM: begin
            s2.x     = scl_qx;
            s2.y     = scl_qy;
            s2.fault = s2.fault | scale_zero;
         end
         MODE_INV, MODE_INVN: ;
      endcase
   end

   // Rotation section; the inverse modes use the conjugate rotor.
   assign rot_conj = (s2.mode == MODE_INV) || (s2.mode == MODE_INVN);

   aff_rot u_rot (
      .clock (clock),
      .a     (s2.x),
      .b     (s2.y),
      .re    (re_c),
      .im    (im_c),
      .conj  (rot_conj),
      .z_x   (rot_x),
      .z_y   (rot_y)
   );

   always_ff @(posedge clock) begin
      rot_d_ff[0] <= s2;
      for (int i = 1; i < ROT_LAT; i++) begin
         rot_d_ff[i] <= rot_d_ff[i-1];
      end
   end

   always_comb begin
      s3   = rot_d_ff[ROT_LAT-1];
      s3.x = rot_x;
      s3.y = rot_y;
   end

   // Post section: add position, divide for inverse, multiply for inverse normal.
   always_comb begin
      post_in = s3;
      if (s3.mode == MODE_FWD) begin
         post_in.x = sat_f(wide_type'(s3.x) + wide_type'(pos_x_ff));
         post_in.y = sat_f(wide_type'(s3.y) + wide_type'(pos_y_ff));
      end
   end

   aff_div u_post_div_x (
      .clock   (clock),
      .a       (s3.x),
      .den     (scl_x_mag),
      .den_neg (scl_x_ff[DATA_WIDTH-1]),
      .q       (post_qx)
   );

   aff_div u_post_div_y (
      .clock   (clock),
      .a       (s3.y),
      .den     (scl_y_mag),
      .den_neg (scl_y_ff[DATA_WIDTH-1]),
      .q       (post_qy)
   );

   aff_mul u_post_mul (
      .clock (clock),
      .a_x   (s3.x),
      .a_y   (s3.y),
      .s_x   (scl_x_ff),
      .s_y   (scl_y_ff),
      .z_x   (post_mx),
      .z_y   (post_my)
   );

   always_ff @(posedge clock) begin
      post_d_ff[0]  <= post_in;
      post_mx_ff[0] <= post_mx;
      post_my_ff[0] <= post_my;
      for (int i = 1; i < DIV_LAT; i++) begin
         post_d_ff[i] <= post_d_ff[i-1];
      end
      for (int i = 1; i < MDLY; i++) begin
         post_mx_ff[i] <= post_mx_ff[i-1];
         post_my_ff[i] <= post_my_ff[i-1];
      end
   end

   always_comb begin
      s4 = post_d_ff[DIV_LAT-1];
      unique case (s4.mode)
         MODE_INV: begin
            s4.x     = post_qx;
            s4.y     = post_qy;
            s4.fault = s4.fault | scale_zero;
         end
         MODE_INVN: begin
            s4.x = post_mx_ff[MDLY-1];
            s4.y = post_my_ff[MDLY-1];
         end
         MODE_FWD, MODE_NRM: ;
      endcase
   end

   // Normalize section: length first, then both components divided by it.
   always_comb begin
      sq_in = s4;
      if (((s4.mode == MODE_NRM) || (s4.mode == MODE_INVN)) &&
          (s4.x == '0) && (s4.y == '0)) begin
         sq_in.fault = 1'b1;
      end
   end

   aff_isqrt u_isqrt (
      .clock (clock),
      .a     (s4.x),
      .b     (s4.y),
      .len   (nrm_len)
   );

   always_ff @(posedge clock) begin
      sq_d_ff[0] <= sq_in;
      for (int i = 1; i < SQRT_LAT; i++) begin
         sq_d_ff[i] <= sq_d_ff[i-1];
      end
   end

   aff_div u_nrm_div_x (
      .clock   (clock),
      .a       (sq_d_ff[SQRT_LAT-1].x),
      .den     (nrm_len),
      .den_neg (1'b0),
      .q       (nrm_qx)
   );

   aff_div u_nrm_div_y (
      .clock   (clock),
      .a       (sq_d_ff[SQRT_LAT-1].y),
      .den     (nrm_len),
      .den_neg (1'b0),
      .q       (nrm_qy)
   );

   always_ff @(posedge clock) begin
      nd_d_ff[0] <= sq_d_ff[SQRT_LAT-1];
      for (int i = 1; i < DIV_LAT; i++) begin
         nd_d_ff[i] <= nd_d_ff[i-1];
      end
   end

   always_comb begin
      s5 = nd_d_ff[DIV_LAT-1];
      unique case (s5.mode)
         MODE_NRM, MODE_INVN: begin
            s5.x = nrm_qx;
            s5.y = nrm_qy;
         end
         MODE_FWD, MODE_INV: ;
      endcase
   end

   // Result register; a faulted request returns zero.
   always_ff @(posedge clock) begin
      rsp_x_ff     <= s5.fault ? '0 : s5.x;
      rsp_y_ff     <= s5.fault ? '0 : s5.y;
      rsp_fault_ff <= s5.fault;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_out_x  = rsp_x_ff;
   assign rsp_out_y  = rsp_y_ff;
   assign rsp_fault  = rsp_fault_ff;

   // A faulted result carries zero in both components.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_fault) |-> (rsp_out_x == '0) && (rsp_out_y == '0))
      else $error("faulted result is not zero");

   // Every accepted request yields a result after the fixed latency.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##RSP_DLY rsp_strobe)
      else $error("accepted request produced no result");

   // Every result traces back to a request accepted at the fixed latency.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, RSP_DLY))
      else $error("result without a matching request");

endmodule
